FILE: hw/rtl/servo_position_ramp_assert.svh
// Assertion macros for the servo position ramp block.
`ifndef SERVO_POSITION_RAMP_ASSERT_SVH
`define SERVO_POSITION_RAMP_ASSERT_SVH

// Check that a condition holds at every clock edge out of reset.
`define SRP_ASSERT_ALWAYS(label, cond) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) \
    else $error("srp invariant violated");

// Check that a consequent holds in the same cycle as its antecedent.
`define SRP_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("srp same-cycle check failed");

// Check that a consequent holds in the cycle after its antecedent.
`define SRP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("srp next-cycle check failed");

`endif

FILE: hw/rtl/srp_pkg.sv
// Shared types, constants and helpers for the servo position ramp.
package srp_pkg;

  localparam int unsigned AngleW   = 8;
  localparam int unsigned TicksW   = 10;
  localparam int unsigned ReqW     = 2;
  localparam int unsigned CfgIdxW  = 8;
  localparam int unsigned CfgDataW = 10;

  localparam logic [AngleW-1:0] MaxAngle = 8'd180;
  localparam logic [TicksW-1:0] TicksMax = 10'h3FF;

  // Request codes
  localparam logic [ReqW-1:0] REQ_TICK  = 2'd0;
  localparam logic [ReqW-1:0] REQ_SET   = 2'd1;
  localparam logic [ReqW-1:0] REQ_RAISE = 2'd2;
  localparam logic [ReqW-1:0] REQ_HOME  = 2'd3;

  // Register indexes
  localparam logic [CfgIdxW-1:0] REG_STEP_SIZE      = 8'd0;
  localparam logic [CfgIdxW-1:0] REG_INTERVAL_TICKS = 8'd1;
  localparam logic [CfgIdxW-1:0] REG_HOME_ANGLE     = 8'd2;
  localparam logic [CfgIdxW-1:0] REG_END_ANGLE      = 8'd3;

  typedef struct packed {
    logic [AngleW-1:0] step_size;
    logic [TicksW-1:0] interval_ticks;
    logic [AngleW-1:0] park_angle;
    logic [AngleW-1:0] raise_angle;
  } cfg_t;

  typedef struct packed {
    logic [AngleW-1:0] cur_pos;
    logic [AngleW-1:0] tgt_pos;
    logic              in_motion;
    logic              raised;
    logic [TicksW-1:0] elapsed;
  } state_t;

  typedef struct packed {
    logic [AngleW-1:0] servo_command;
    logic              servo_written;
    logic [AngleW-1:0] logical_angle;
    logic              barrier_raised;
    logic              moving;
  } result_t;

  // Clamp an angle to the servo range.
  function automatic logic [AngleW-1:0] sat_angle(input logic [AngleW-1:0] a);
    sat_angle = (a > MaxAngle) ? MaxAngle : a;
  endfunction

endpackage

FILE: hw/rtl/srp_step.sv
// Next-state and result logic for one request word.
module srp_step (
  input  srp_pkg::cfg_t                 cfg_i,
  input  srp_pkg::state_t               state_i,
  input  logic [srp_pkg::ReqW-1:0]      req_type_i,
  input  logic [srp_pkg::AngleW-1:0]    requested_angle_i,
  output srp_pkg::state_t               state_o,
  output srp_pkg::result_t              result_o
);
  import srp_pkg::*;

  logic [TicksW-1:0] elapsed_inc;
  logic [AngleW:0]   up_sum;
  logic [AngleW-1:0] down_val;
  logic [AngleW-1:0] aim_src;
  logic [AngleW-1:0] aim_tgt;
  logic              written;

  // Saturating tick count and step candidates
  assign elapsed_inc = (state_i.elapsed != TicksMax) ? state_i.elapsed + 10'd1
                                                     : state_i.elapsed;
  assign up_sum   = {1'b0, state_i.cur_pos} + {1'b0, cfg_i.step_size};
  assign down_val = (cfg_i.step_size >= state_i.cur_pos) ? '0
                                                         : state_i.cur_pos - cfg_i.step_size;

  // Pick the target source for aiming requests
  always_comb begin
    case (req_type_i)
      REQ_SET:   aim_src = requested_angle_i;
      REQ_RAISE: aim_src = cfg_i.raise_angle;
      REQ_HOME:  aim_src = cfg_i.park_angle;
      default:   aim_src = state_i.tgt_pos;
    endcase
  end
  assign aim_tgt = sat_angle(aim_src);

  // Apply the request to the state
  always_comb begin
    state_o = state_i;
    written = 1'b0;
    case (req_type_i)
      REQ_TICK: begin
        state_o.elapsed = elapsed_inc;
        if (elapsed_inc >= cfg_i.interval_ticks) begin
          state_o.elapsed = '0;
          if (state_i.in_motion) begin
            written = 1'b1;
            if (state_i.cur_pos < state_i.tgt_pos) begin
              if (up_sum >= {1'b0, state_i.tgt_pos}) begin
                state_o.cur_pos   = state_i.tgt_pos;
                state_o.in_motion = 1'b0;
              end else begin
                state_o.cur_pos = up_sum[AngleW-1:0];
              end
            end else if (state_i.cur_pos > state_i.tgt_pos) begin
              if (down_val <= state_i.tgt_pos) begin
                state_o.cur_pos   = state_i.tgt_pos;
                state_o.in_motion = 1'b0;
              end else begin
                state_o.cur_pos = down_val;
              end
            end else begin
              state_o.in_motion = 1'b0;
            end
          end
        end
      end
      REQ_SET: begin
        state_o.tgt_pos   = aim_tgt;
        state_o.in_motion = (aim_tgt != state_i.cur_pos);
      end
      REQ_RAISE: begin
        state_o.raised  = 1'b1;
        state_o.tgt_pos = aim_tgt;
        if (aim_tgt != state_i.cur_pos) begin
          state_o.in_motion = 1'b1;
        end
      end
      default: begin
        state_o.raised  = 1'b0;
        state_o.tgt_pos = aim_tgt;
        state_o.elapsed = '0;
        if (aim_tgt != state_i.cur_pos) begin
          state_o.in_motion = 1'b1;
        end
      end
    endcase
  end

  // Build the result word from the updated state
  always_comb begin
    result_o.servo_command  = MaxAngle - sat_angle(state_o.cur_pos);
    result_o.servo_written  = written;
    result_o.logical_angle  = state_o.cur_pos;
    result_o.barrier_raised = state_o.raised;
    result_o.moving         = state_o.in_motion;
  end

endmodule

FILE: hw/rtl/servo_position_ramp.sv
// Servo position ramp: slew-rate limited servo angle, top level.
// Data path: a request word is held in the input register, goes through srp_step and
//   is held in the result register until taken; a full result register stalls it.
// Throughput: one word per cycle; the input register and the result register
//   both advance whenever the result register is empty or being taken.
// Reset: async active low; registers return to step 10, interval 20, home 0,
//   end 180, angle and target 0, idle, not raised, tick count 0.
`include "servo_position_ramp_assert.svh"

module servo_position_ramp (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [srp_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [srp_pkg::CfgDataW-1:0]   cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [srp_pkg::ReqW-1:0]       req_type_i,
  input  logic [srp_pkg::AngleW-1:0]     requested_angle_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [srp_pkg::AngleW-1:0]     servo_command_o,
  output logic                           servo_written_o,
  output logic [srp_pkg::AngleW-1:0]     logical_angle_o,
  output logic                           barrier_raised_o,
  output logic                           moving_o
);
  import srp_pkg::*;

  cfg_t              cfg_q;
  state_t            state_q, state_d;
  result_t           res_d, res_q;
  logic              in_valid_q;
  logic [ReqW-1:0]   req_q;
  logic [AngleW-1:0] ang_q;
  logic              out_valid_q;
  logic              advance;

  // Move the held word forward when the result register can take it
  assign advance     = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o  = !in_valid_q || advance;
  assign cfg_ready_o = 1'b1;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.step_size      <= 8'd10;
      cfg_q.interval_ticks <= 10'd20;
      cfg_q.park_angle     <= 8'd0;
      cfg_q.raise_angle    <= 8'd180;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_STEP_SIZE:      cfg_q.step_size      <= cfg_data_i[AngleW-1:0];
        REG_INTERVAL_TICKS: cfg_q.interval_ticks <= cfg_data_i[TicksW-1:0];
        REG_HOME_ANGLE:     cfg_q.park_angle     <= cfg_data_i[AngleW-1:0];
        REG_END_ANGLE:      cfg_q.raise_angle    <= cfg_data_i[AngleW-1:0];
        default: ;
      endcase
    end
  end

  // Input register: hold the request word until it advances
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      req_q <= req_type_i;
      ang_q <= requested_angle_i;
    end
  end

  srp_step u_step (
    .cfg_i             (cfg_q),
    .state_i           (state_q),
    .req_type_i        (req_q),
    .requested_angle_i (ang_q),
    .state_o           (state_d),
    .result_o          (res_d)
  );

  // Servo state: update once per advancing word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (advance) begin
      state_q <= state_d;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign servo_command_o  = res_q.servo_command;
  assign servo_written_o  = res_q.servo_written;
  assign logical_angle_o  = res_q.logical_angle;
  assign barrier_raised_o = res_q.barrier_raised;
  assign moving_o         = res_q.moving;

  // Assertions
  `SRP_ASSERT_ALWAYS(a_pos_in_range, (state_q.cur_pos <= MaxAngle) && (state_q.tgt_pos <= MaxAngle))
  `SRP_ASSERT_SAME(a_stall_blocks, (in_valid_q && out_valid_q && !out_ready_i), !in_ready_o)
  `SRP_ASSERT_NEXT(a_advance_fills, advance, out_valid_q)
  `SRP_ASSERT_SAME(a_idle_on_target, (!state_q.in_motion && advance && req_q == REQ_TICK), !res_d.servo_written)

endmodule
